// ----- rtl/bps_pkg.sv -----
`default_nettype none
package bps_pkg;

	// Field widths
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned LEVEL_W = 2;
	localparam int unsigned REP_W   = 3;
	localparam int unsigned DUR_W   = 11;

	// Command codes
	localparam logic CMD_SET  = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Alarm levels
	localparam logic [LEVEL_W-1:0] LVL_NONE    = 2'd0;
	localparam logic [LEVEL_W-1:0] LVL_SHORT   = 2'd1;
	localparam logic [LEVEL_W-1:0] LVL_WARNING = 2'd2;
	localparam logic [LEVEL_W-1:0] LVL_HIGH    = 2'd3;

	// Largest repeat count of any pattern
	localparam logic [REP_W-1:0] REP_MAX = 3'd5;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_ON    = 2'd1,
		PH_OFF   = 2'd2,
		PH_PAUSE = 2'd3
	} phase_t;

	typedef struct packed {
		logic [DUR_W-1:0] on_ms;
		logic [DUR_W-1:0] off_ms;
		logic [REP_W-1:0] repeats;
		logic [DUR_W-1:0] rest_ms;
	} pattern_t;

	// Fixed beep pattern for each alarm level
	function automatic pattern_t pattern_of(input logic [LEVEL_W-1:0] level);
		pattern_t p;
		case (level)
			LVL_SHORT:   p = '{on_ms: 11'd100, off_ms: 11'd0,   repeats: 3'd1, rest_ms: 11'd0};
			LVL_WARNING: p = '{on_ms: 11'd200, off_ms: 11'd300, repeats: 3'd3, rest_ms: 11'd1000};
			LVL_HIGH:    p = '{on_ms: 11'd100, off_ms: 11'd100, repeats: 3'd5, rest_ms: 11'd500};
			default:     p = '{on_ms: 11'd0,   off_ms: 11'd0,   repeats: 3'd0, rest_ms: 11'd0};
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/bps_in_if.sv -----
`default_nettype none
interface bps_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [1:0]  new_level;
	logic [31:0] now_ms;

	modport source (output valid, command, new_level, now_ms, input ready);
	modport sink (input valid, command, new_level, now_ms, output ready);
endinterface
`default_nettype wire

// ----- rtl/bps_out_if.sv -----
`default_nettype none
interface bps_out_if;
	logic       valid;
	logic       ready;
	logic       beep_on;
	logic       buzzer_changed;
	logic [1:0] phase;
	logic [2:0] repeats_done;
	logic [1:0] active_level;

	modport source (output valid, beep_on, buzzer_changed, phase, repeats_done,
		active_level, input ready);
	modport sink (input valid, beep_on, buzzer_changed, phase, repeats_done,
		active_level, output ready);
endinterface
`default_nettype wire

// ----- rtl/buzzer_pattern_sequencer.sv -----
// Channel  | Dir | Payload                                                 | Handshake
// item     | in  | command, new_level, now_ms                              | valid/ready
// result   | out | beep_on, buzzer_changed, phase, repeats_done, active_level | valid/ready
//
// Each request is captured in an input register; the pattern state is then
// updated and the result is written to the output register.
// One request is accepted every cycle while the result is not stalled.
// Throughput is set by the single state-update step (one 32-bit subtract and compare).
// arst_n clears the alarm level, phase, start time, repeat count and drive.
// A stalled result holds both registers; requests are taken again as soon as it drains.
`default_nettype none
module buzzer_pattern_sequencer (
	input  wire logic clk,
	input  wire logic arst_n,
	bps_in_if.sink    item,
	bps_out_if.source result
);
	import bps_pkg::*;

	// Input stage
	logic               valid_s1;
	logic               command_s1;
	logic [LEVEL_W-1:0] level_s1;
	logic [TIME_W-1:0]  now_s1;

	// Pattern state
	logic [LEVEL_W-1:0] level_q;
	phase_t             phase_q;
	logic [TIME_W-1:0]  start_q;
	logic [REP_W-1:0]   rep_q;
	logic               drive_q;

	// Result register
	logic               res_valid_q;
	logic               res_on_q;
	logic               res_changed_q;
	phase_t             res_phase_q;
	logic [REP_W-1:0]   res_rep_q;
	logic [LEVEL_W-1:0] res_level_q;

	// Next state
	logic [LEVEL_W-1:0] level_d;
	phase_t             phase_d;
	logic [TIME_W-1:0]  start_d;
	logic [REP_W-1:0]   rep_d;
	logic               drive_d;

	logic               advance;
	pattern_t           pat;
	logic [TIME_W-1:0]  elapsed;
	logic [REP_W-1:0]   rep_inc;

	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	// Capture the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			command_s1 <= item.command;
			level_s1   <= item.new_level;
			now_s1     <= item.now_ms;
		end
	end

	// Work out the next phase from the current pattern
	assign pat     = pattern_of(level_q);
	assign elapsed = now_s1 - start_q;
	assign rep_inc = rep_q + 3'd1;

	always_comb begin
		level_d = level_q;
		phase_d = phase_q;
		start_d = start_q;
		rep_d   = rep_q;
		drive_d = drive_q;
		if (command_s1 == CMD_SET) begin
			if (level_s1 != level_q) begin
				level_d = level_s1;
				rep_d   = '0;
				if (level_s1 == LVL_NONE) begin
					phase_d = PH_IDLE;
					start_d = '0;
					drive_d = 1'b0;
				end
			end
		end else if (level_q == LVL_NONE) begin
			if (phase_q != PH_IDLE) begin
				phase_d = PH_IDLE;
				start_d = now_s1;
				drive_d = 1'b0;
			end
		end else begin
			case (phase_q)
				PH_IDLE: begin
					rep_d   = '0;
					phase_d = PH_ON;
					start_d = now_s1;
					drive_d = 1'b1;
				end
				PH_ON: begin
					if (elapsed >= {{(TIME_W-DUR_W){1'b0}}, pat.on_ms}) begin
						start_d = now_s1;
						rep_d   = rep_inc;
						if (pat.repeats != '0 && rep_inc >= pat.repeats) begin
							if (pat.rest_ms != '0) begin
								phase_d = PH_PAUSE;
								drive_d = 1'b0;
							end else begin
								// group done with no pause: restart the beep
								rep_d   = '0;
								phase_d = PH_ON;
								drive_d = 1'b1;
							end
						end else begin
							phase_d = PH_OFF;
							drive_d = 1'b0;
						end
					end
				end
				PH_OFF: begin
					if (elapsed >= {{(TIME_W-DUR_W){1'b0}}, pat.off_ms}) begin
						phase_d = PH_ON;
						start_d = now_s1;
						drive_d = 1'b1;
					end
				end
				default: begin
					if (elapsed >= {{(TIME_W-DUR_W){1'b0}}, pat.rest_ms}) begin
						rep_d   = '0;
						phase_d = PH_ON;
						start_d = now_s1;
						drive_d = 1'b1;
					end
				end
			endcase
		end
	end

	// Commit the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= LVL_NONE;
			phase_q <= PH_IDLE;
			start_q <= '0;
			rep_q   <= '0;
			drive_q <= 1'b0;
		end else if (advance) begin
			level_q <= level_d;
			phase_q <= phase_d;
			start_q <= start_d;
			rep_q   <= rep_d;
			drive_q <= drive_d;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_on_q      <= drive_d;
			res_changed_q <= drive_d != drive_q;
			res_phase_q   <= phase_d;
			res_rep_q     <= rep_d;
			res_level_q   <= level_d;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.beep_on        = res_on_q;
	assign result.buzzer_changed = res_changed_q;
	assign result.phase          = 2'(res_phase_q);
	assign result.repeats_done   = res_rep_q;
	assign result.active_level   = res_level_q;

	// Drive follows the on phase
	a_drive_phase: assert property (@(posedge clk) disable iff (!arst_n)
		drive_q == (phase_q == PH_ON))
		else $error("buzzer drive out of step with phase");

	// Level none keeps the sequencer idle
	a_none_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(level_q == LVL_NONE) |-> (phase_q == PH_IDLE))
		else $error("sequencer active at level none");

	// Repeat count stays within the longest group
	a_rep_range: assert property (@(posedge clk) disable iff (!arst_n)
		rep_q <= REP_MAX)
		else $error("repeat count out of range");

	// Every processed request leaves a result
	a_result_after: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("processed request produced no result");

	// State moves only when a request is processed
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(level_q) && $stable(phase_q) && $stable(rep_q))
		else $error("state changed without a request");

endmodule
`default_nettype wire
